@@ src/bmp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap range painter package
// Shared constants, register indexes and the request descriptor that the
// front end hands to the paint engine through the request queue.
// ----------------------------------------------------------------------------
package bmp_pkg;

  // Bitmap geometry. WORD_BITS is expected to be a power of two.
  localparam int WORD_BITS    = 64;
  localparam int MAP_WORDS    = 64;
  localparam int GRANULE_LOG2 = 3;

  localparam int ADDR_W    = 32;
  localparam int BIT_W     = ADDR_W - GRANULE_LOG2;
  localparam int WORD_LOG2 = $clog2(WORD_BITS);
  localparam int OFF_W     = WORD_LOG2;
  localparam int IDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  // Port widths fixed by the interface.
  localparam int MAPW_W    = 7;
  localparam int OUT_IDX_W = 6;
  localparam int OUT_VAL_W = 64;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  // Register indexes on the configuration port (byte address 4*index).
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_AT_BASE   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MAP_WORDS = 1'b1;

  // Request queue depth, a power of two.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

  typedef struct packed {
    logic             err;
    logic             set;
    logic [IDX_W-1:0] first_w;
    logic [IDX_W-1:0] last_w;
    logic [OFF_W-1:0] lo_off;
    logic [OFF_W-1:0] hi_off;
  } paint_desc_t;

endpackage

@@ src/bmp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bmp_ram #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                     wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                     rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/bmp_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request queue
// Short queue of classified paint requests between the front end and the
// paint engine.
// ----------------------------------------------------------------------------
module bmp_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  bmp_pkg::paint_desc_t push_desc,
  output logic                 full,
  input  logic                 pop,
  output bmp_pkg::paint_desc_t pop_desc,
  output logic                 empty
);

  bmp_pkg::paint_desc_t              mem_r [bmp_pkg::FIFO_DEPTH];
  logic [bmp_pkg::FIFO_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [bmp_pkg::FIFO_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [bmp_pkg::FIFO_PTR_W:0]      cnt_r, cnt_nxt;

  assign full     = (cnt_r == (bmp_pkg::FIFO_PTR_W + 1)'(bmp_pkg::FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_desc = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (bmp_pkg::FIFO_PTR_W + 1)'(bmp_pkg::FIFO_DEPTH))
    else $error("request queue holds more entries than its depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty && !(push && full))
    else $error("request queue popped while empty or pushed while full");

endmodule

@@ src/bmp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request front end
// Offsets a request by the bitmap base, registers the granule bounds and
// classifies the range into a paint descriptor or a rejection.
// ----------------------------------------------------------------------------
module bmp_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bmp_pkg::ADDR_W-1:0]        in_range_base,
  input  logic [bmp_pkg::ADDR_W-1:0]        in_range_top,
  input  logic                              in_revoke,
  input  logic [bmp_pkg::ADDR_W-1:0]        at_base,
  input  logic [bmp_pkg::MAPW_W-1:0]        map_words,
  output logic                              push,
  output bmp_pkg::paint_desc_t              push_desc,
  input  logic                              full
);

  logic                         s1_vld_r, s1_vld_nxt;
  logic [bmp_pkg::BIT_W-1:0]    s1_start_r, s1_end_r;
  logic                         s1_set_r;

  logic [bmp_pkg::ADDR_W-1:0]   lo_off, hi_off;
  logic [bmp_pkg::BIT_W-1:0]    words, limit;
  logic                         take;

  assign in_ready = !s1_vld_r || !full;
  assign take     = in_valid && in_ready;
  assign push     = s1_vld_r && !full;

  // The end bound adds one granule less two bytes before the shift.
  assign lo_off = in_range_base - at_base;
  assign hi_off = in_range_top - at_base
                  + bmp_pkg::ADDR_W'((1 << bmp_pkg::GRANULE_LOG2) - 2);

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (take) begin
      s1_vld_nxt = 1'b1;
    end else if (push) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_start_r <= lo_off[bmp_pkg::ADDR_W-1:bmp_pkg::GRANULE_LOG2];
      s1_end_r   <= hi_off[bmp_pkg::ADDR_W-1:bmp_pkg::GRANULE_LOG2];
      s1_set_r   <= in_revoke;
    end
  end

  // A word count above the store depth saturates to the depth.
  always_comb begin
    if (bmp_pkg::BIT_W'(map_words) > bmp_pkg::BIT_W'(bmp_pkg::MAP_WORDS)) begin
      words = bmp_pkg::BIT_W'(bmp_pkg::MAP_WORDS);
    end else begin
      words = bmp_pkg::BIT_W'(map_words);
    end
    limit = words << bmp_pkg::WORD_LOG2;

    push_desc.err     = (s1_start_r >= s1_end_r) || (s1_end_r >= limit);
    push_desc.set     = s1_set_r;
    push_desc.first_w = bmp_pkg::IDX_W'(s1_start_r >> bmp_pkg::WORD_LOG2);
    push_desc.last_w  = bmp_pkg::IDX_W'(s1_end_r >> bmp_pkg::WORD_LOG2);
    push_desc.lo_off  = s1_start_r[bmp_pkg::OFF_W-1:0];
    push_desc.hi_off  = s1_end_r[bmp_pkg::OFF_W-1:0];
  end

endmodule

@@ src/bmp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paint engine
// Walks the words of one request, doing a read-modify-write of each word in
// the bitmap store and reporting the new contents through an output register.
// ----------------------------------------------------------------------------
module bmp_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fifo_empty,
  input  bmp_pkg::paint_desc_t              fifo_desc,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_status,
  output logic [bmp_pkg::OUT_IDX_W-1:0]     out_word_index,
  output logic [bmp_pkg::OUT_VAL_W-1:0]     out_word_value,
  output logic                              out_last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ERR,
    ST_RD,
    ST_MOD
  } st_t;

  st_t                              state_r, state_nxt;
  bmp_pkg::paint_desc_t             desc_r, desc_nxt;
  logic [bmp_pkg::IDX_W-1:0]        w_r, w_nxt;
  logic [bmp_pkg::WORD_BITS-1:0]    mask_r, mask_nxt;
  logic [bmp_pkg::MAP_WORDS-1:0]    vbit_r, vbit_nxt;

  logic                             out_vld_r, out_vld_nxt;
  logic                             out_status_r, out_status_nxt;
  logic [bmp_pkg::OUT_IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic [bmp_pkg::OUT_VAL_W-1:0]    out_val_r, out_val_nxt;
  logic                             out_last_r, out_last_nxt;

  logic                             out_free;
  logic                             ram_we, ram_re;
  logic [bmp_pkg::WORD_BITS-1:0]    ram_rdata, old_val, new_val;
  logic [bmp_pkg::OFF_W-1:0]        lo_bit, hi_bit;

  bmp_ram #(
    .DATA_W (bmp_pkg::WORD_BITS),
    .DEPTH  (bmp_pkg::MAP_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w_r),
    .wdata (new_val),
    .re    (ram_re),
    .raddr (w_r),
    .rdata (ram_rdata)
  );

  assign out_free = !out_vld_r || out_ready;

  // Bit bounds within the current word: the range ends apply only at the
  // first and last word.
  assign lo_bit = (w_r == desc_r.first_w) ? desc_r.lo_off : '0;
  assign hi_bit = (w_r == desc_r.last_w) ? desc_r.hi_off
                                         : bmp_pkg::OFF_W'(bmp_pkg::WORD_BITS - 1);

  // A word never written since reset reads as zero.
  assign old_val = vbit_r[w_r] ? ram_rdata : '0;
  assign new_val = desc_r.set ? (old_val | mask_r) : (old_val & ~mask_r);

  always_comb begin
    state_nxt      = state_r;
    desc_nxt       = desc_r;
    w_nxt          = w_r;
    mask_nxt       = mask_r;
    vbit_nxt       = vbit_r;
    out_vld_nxt    = out_vld_r && !out_ready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_val_nxt    = out_val_r;
    out_last_nxt   = out_last_r;
    pop            = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!fifo_empty) begin
          pop       = 1'b1;
          desc_nxt  = fifo_desc;
          w_nxt     = fifo_desc.first_w;
          state_nxt = fifo_desc.err ? ST_ERR : ST_RD;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = 1'b1;
          out_idx_nxt    = '0;
          out_val_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        mask_nxt  = (bmp_pkg::WORD_ONES << lo_bit)
                    & (bmp_pkg::WORD_ONES
                       >> (bmp_pkg::OFF_W'(bmp_pkg::WORD_BITS - 1) - hi_bit));
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (out_free) begin
          ram_we         = 1'b1;
          vbit_nxt[w_r]  = 1'b1;
          out_vld_nxt    = 1'b1;
          out_status_nxt = 1'b0;
          out_idx_nxt    = bmp_pkg::OUT_IDX_W'(w_r);
          out_val_nxt    = bmp_pkg::OUT_VAL_W'(new_val);
          out_last_nxt   = (w_r == desc_r.last_w);
          if (w_r == desc_r.last_w) begin
            state_nxt = ST_IDLE;
          end else begin
            w_nxt     = w_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      vbit_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      vbit_r    <= vbit_nxt;
      out_vld_r <= out_vld_nxt;
    end
    desc_r       <= desc_nxt;
    w_r          <= w_nxt;
    mask_r       <= mask_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_val_r    <= out_val_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_vld_r;
  assign out_status     = out_status_r;
  assign out_word_index = out_idx_r;
  assign out_word_value = out_val_r;
  assign out_last       = out_last_r;

  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_status_r |-> out_last_r && out_idx_r == '0 && out_val_r == '0)
    else $error("rejection result carries word data");

  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD || state_r == ST_MOD) |-> w_r >= desc_r.first_w && w_r <= desc_r.last_w)
    else $error("paint walk left the requested word range");

endmodule

@@ src/bitmap_range_painter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap range painter
// Sets or clears the granule bits of a byte range in a revocation bitmap.
// ----------------------------------------------------------------------------
// A request enters the front end, which takes one request per cycle while the
// request queue has room and classifies it in the following cycle. The paint
// engine then takes the request from the queue in its idle state and handles
// each bitmap word as a read followed by a modify-write, while a rejected
// request goes to an error state that reports it. Results leave through an
// output register, so the engine can fetch the next request or read the next
// word while the previous result waits for its transfer, but it holds before
// the next write or report. The bitmap reads as all zeros right after reset
// without any clearing pass.
// ----------------------------------------------------------------------------
module bitmap_range_painter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bmp_pkg::ADDR_W-1:0]        in_range_base,
  input  logic [bmp_pkg::ADDR_W-1:0]        in_range_top,
  input  logic                              in_revoke,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_status,
  output logic [bmp_pkg::OUT_IDX_W-1:0]     out_word_index,
  output logic [bmp_pkg::OUT_VAL_W-1:0]     out_word_value,
  output logic                              out_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bmp_pkg::CFG_AW-1:0]        paddr,
  input  logic [bmp_pkg::CFG_DW-1:0]        pwdata,
  output logic [bmp_pkg::CFG_DW-1:0]        prdata,
  output logic                              pready
);

  logic [bmp_pkg::ADDR_W-1:0]    at_base_r, at_base_nxt;
  logic [bmp_pkg::MAPW_W-1:0]    map_words_r, map_words_nxt;
  logic [bmp_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;

  logic                          q_push, q_pop, q_full, q_empty;
  bmp_pkg::paint_desc_t          q_push_desc, q_pop_desc;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[bmp_pkg::CFG_AW-1:2];

  always_comb begin
    at_base_nxt   = at_base_r;
    map_words_nxt = map_words_r;
    unique case (reg_idx)
      bmp_pkg::REG_AT_BASE: begin
        prdata = at_base_r;
        if (cfg_wr) begin
          at_base_nxt = pwdata;
        end
      end
      bmp_pkg::REG_MAP_WORDS: begin
        prdata = bmp_pkg::CFG_DW'(map_words_r);
        if (cfg_wr) begin
          map_words_nxt = pwdata[bmp_pkg::MAPW_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_base_r   <= '0;
      map_words_r <= '0;
    end else begin
      at_base_r   <= at_base_nxt;
      map_words_r <= map_words_nxt;
    end
  end

  bmp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_range_base (in_range_base),
    .in_range_top  (in_range_top),
    .in_revoke     (in_revoke),
    .at_base       (at_base_r),
    .map_words     (map_words_r),
    .push          (q_push),
    .push_desc     (q_push_desc),
    .full          (q_full)
  );

  bmp_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .pop_desc  (q_pop_desc),
    .empty     (q_empty)
  );

  bmp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .fifo_empty     (q_empty),
    .fifo_desc      (q_pop_desc),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_word_index (out_word_index),
    .out_word_value (out_word_value),
    .out_last       (out_last)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap range painter testbench
// Drives byte-range paint requests and register writes into the painter and
// checks every reported bitmap word against a cycle-free model of the bitmap.
// ----------------------------------------------------------------------------
module tb;

  localparam int IDLE_PCT      = 10;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 40;
  localparam int STALL_LIMIT   = 2000;
  localparam int SINK_HOLD     = 300;
  localparam int NUM_PHASES    = 7;
  localparam int PHASE_ITEMS   = 57;
  localparam int NUM_DIRECTED  = 25;

  typedef struct packed {
    logic                          status;
    logic [bmp_pkg::OUT_IDX_W-1:0] word_index;
    logic [bmp_pkg::OUT_VAL_W-1:0] word_value;
    logic                          last;
  } word_report_t;

  typedef enum logic [1:0] {ROW_PAINT, ROW_AT_BASE, ROW_MAP_WORDS} row_kind_t;

  // For register rows the value travels in range_base.
  typedef struct packed {
    row_kind_t    kind;
    logic [31:0]  range_base;
    logic [31:0]  range_top;
    logic         revoke;
    logic         typed;
    word_report_t report;
  } directed_row_t;

  localparam word_report_t REJECTED   = '{1'b1, '0, '0, 1'b1};
  localparam word_report_t LOW_PAIR   = '{1'b0, '0, 64'h3, 1'b1};
  localparam word_report_t NO_REPORT  = '0;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [bmp_pkg::ADDR_W-1:0]    in_range_base;
  logic [bmp_pkg::ADDR_W-1:0]    in_range_top;
  logic                          in_revoke;
  logic                          out_valid;
  logic                          out_ready;
  logic                          out_status;
  logic [bmp_pkg::OUT_IDX_W-1:0] out_word_index;
  logic [bmp_pkg::OUT_VAL_W-1:0] out_word_value;
  logic                          out_last;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [bmp_pkg::CFG_AW-1:0]    paddr;
  logic [bmp_pkg::CFG_DW-1:0]    pwdata;
  logic [bmp_pkg::CFG_DW-1:0]    prdata;
  logic                          pready;

  // Model of the block: register copies and the bitmap contents.
  logic [31:0]                   model_at_base;
  logic [bmp_pkg::MAPW_W-1:0]    model_map_words;
  logic [bmp_pkg::WORD_BITS-1:0] bitmap_model [bmp_pkg::MAP_WORDS];

  word_report_t fresh_reports [$];
  word_report_t pending_reports [$];

  int idle_pct = IDLE_PCT;
  int sink_hold_len = 0;
  int stall_cycles = 0;
  int mismatch_count = 0;
  int requests_sent = 0;
  int rejects_expected = 0;
  int reports_checked = 0;
  int settings_written = 0;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    // Map size is still zero after reset, so everything bounces.
    '{ROW_PAINT,     32'h0000_0000, 32'h0000_0040, 1'b1, 1'b1, REJECTED},
    '{ROW_PAINT,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, REJECTED},
    '{ROW_MAP_WORDS, 32'd64,        32'h0,         1'b0, 1'b0, NO_REPORT},
    '{ROW_PAINT,     32'h0000_0000, 32'h0000_0008, 1'b1, 1'b1, LOW_PAIR},
    '{ROW_PAINT,     32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, REJECTED},
    '{ROW_PAINT,     32'h0000_0010, 32'h0000_0008, 1'b1, 1'b1, REJECTED},
    '{ROW_PAINT,     32'h0000_0000, 32'h0000_8000, 1'b1, 1'b1, REJECTED},
    '{ROW_PAINT,     32'h0000_0000, 32'h0000_7FF9, 1'b1, 1'b0, NO_REPORT},
    '{ROW_PAINT,     32'h0000_0064, 32'h0000_03E8, 1'b0, 1'b0, NO_REPORT},
    '{ROW_PAINT,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, REJECTED},
    '{ROW_PAINT,     32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, REJECTED},
    '{ROW_PAINT,     32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, REJECTED},
    '{ROW_AT_BASE,   32'hFFFF_FFC0, 32'h0,         1'b0, 1'b0, NO_REPORT},
    '{ROW_PAINT,     32'hFFFF_FFC0, 32'h0000_0040, 1'b1, 1'b0, NO_REPORT},
    '{ROW_PAINT,     32'h0000_0000, 32'h0000_0100, 1'b0, 1'b0, NO_REPORT},
    '{ROW_MAP_WORDS, 32'd100,       32'h0,         1'b0, 1'b0, NO_REPORT},
    '{ROW_PAINT,     32'h0000_7CC0, 32'h0000_7FB8, 1'b1, 1'b0, NO_REPORT},
    '{ROW_PAINT,     32'hFFFF_FFC0, 32'h0000_7FC0, 1'b1, 1'b1, REJECTED},
    '{ROW_MAP_WORDS, 32'd127,       32'h0,         1'b0, 1'b0, NO_REPORT},
    '{ROW_PAINT,     32'h0000_01B8, 32'h0000_01C0, 1'b0, 1'b0, NO_REPORT},
    '{ROW_MAP_WORDS, 32'd1,         32'h0,         1'b0, 1'b0, NO_REPORT},
    '{ROW_PAINT,     32'hFFFF_FFC0, 32'h0000_01BA, 1'b1, 1'b1, REJECTED},
    '{ROW_PAINT,     32'hFFFF_FFC0, 32'h0000_01B8, 1'b1, 1'b0, NO_REPORT},
    '{ROW_PAINT,     32'hFFFF_FFC7, 32'h0000_01B0, 1'b0, 1'b0, NO_REPORT},
    '{ROW_AT_BASE,   32'h0000_0000, 32'h0,         1'b0, 1'b0, NO_REPORT}
  };

  bitmap_range_painter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_range_base  (in_range_base),
    .in_range_top   (in_range_top),
    .in_revoke      (in_revoke),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_word_index (out_word_index),
    .out_word_value (out_word_value),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Works out the words that one paint request rewrites, lowest first, and
  // updates the model bitmap. The end bit is included in the painted span.
  function automatic void paint_bitmap(logic [31:0] range_base, logic [31:0] range_top,
                                       logic revoke);
    logic [31:0]                   lo_off;
    logic [31:0]                   hi_off;
    logic [bmp_pkg::WORD_BITS-1:0] sel;
    logic [bmp_pkg::WORD_BITS-1:0] val;
    int unsigned                   words;
    int unsigned                   limit;
    int unsigned                   start_bit;
    int unsigned                   end_bit;
    int unsigned                   first_w;
    int unsigned                   last_w;
    fresh_reports.delete();
    words = (model_map_words > bmp_pkg::MAP_WORDS) ? bmp_pkg::MAP_WORDS : model_map_words;
    limit = words * bmp_pkg::WORD_BITS;
    lo_off = range_base - model_at_base;
    hi_off = range_top - model_at_base + 32'((1 << bmp_pkg::GRANULE_LOG2) - 2);
    start_bit = lo_off >> bmp_pkg::GRANULE_LOG2;
    end_bit = hi_off >> bmp_pkg::GRANULE_LOG2;
    if (start_bit >= end_bit || end_bit >= limit) begin
      fresh_reports.push_back(REJECTED);
      return;
    end
    first_w = start_bit / bmp_pkg::WORD_BITS;
    last_w = end_bit / bmp_pkg::WORD_BITS;
    sel = bmp_pkg::WORD_ONES << (start_bit % bmp_pkg::WORD_BITS);
    for (int unsigned w = first_w; w <= last_w; w++) begin
      if (w == last_w) begin
        sel &= bmp_pkg::WORD_ONES
               >> (bmp_pkg::WORD_BITS - 1 - end_bit % bmp_pkg::WORD_BITS);
      end
      val = (bitmap_model[w] & ~sel) | (revoke ? sel : '0);
      bitmap_model[w] = val;
      fresh_reports.push_back('{1'b0, bmp_pkg::OUT_IDX_W'(w), bmp_pkg::OUT_VAL_W'(val),
                                w == last_w});
      sel = bmp_pkg::WORD_ONES;
    end
  endfunction

  function automatic void queue_reports();
    foreach (fresh_reports[i]) begin
      pending_reports.push_back(fresh_reports[i]);
      if (fresh_reports[i].status) rejects_expected++;
    end
  endfunction

  // Holds the request until the painter takes it; in_valid stays high after
  // the transfer so a following request can go out without a bubble.
  task automatic send_paint(input logic [31:0] range_base, input logic [31:0] range_top,
                            input logic revoke);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_range_base <= range_base;
    in_range_top <= range_top;
    in_revoke <= revoke;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    paint_bitmap(range_base, range_top, revoke);
    requests_sent++;
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bmp_pkg::REG_IDX_W-1:0] reg_idx,
                           input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (reg_idx)
      bmp_pkg::REG_AT_BASE:   model_at_base = value;
      bmp_pkg::REG_MAP_WORDS: model_map_words = value[bmp_pkg::MAPW_W-1:0];
      default: ;
    endcase
    settings_written++;
  endtask

  task automatic check_report();
    word_report_t expected;
    if (pending_reports.size() == 0) begin
      $error("unexpected word report: index %0d value %h", out_word_index, out_word_value);
      mismatch_count++;
      return;
    end
    expected = pending_reports.pop_front();
    reports_checked++;
    if (out_status !== expected.status) begin
      $error("status: expected %0d, got %0d", expected.status, out_status);
      mismatch_count++;
    end
    if (out_word_index !== expected.word_index) begin
      $error("word_index: expected %0d, got %0d", expected.word_index, out_word_index);
      mismatch_count++;
    end
    if (out_word_value !== expected.word_value) begin
      $error("word_value: expected %h, got %h", expected.word_value, out_word_value);
      mismatch_count++;
    end
    if (out_last !== expected.last) begin
      $error("last: expected %0d, got %0d", expected.last, out_last);
      mismatch_count++;
    end
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_report();
      if (sink_hold_len != 0) begin
        out_ready <= 1'b0;
        repeat (sink_hold_len) @(posedge clk);
        sink_hold_len = 0;
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [31:0]                phase_at_base [NUM_PHASES];
    logic [bmp_pkg::MAPW_W-1:0] phase_map_words [NUM_PHASES];
    logic [31:0]                range_base;
    logic [31:0]                range_top;
    logic                       revoke;
    int unsigned                words;
    int unsigned                limit;
    int unsigned                start_bit;
    int unsigned                end_bit;
    int unsigned                span;
    int unsigned                pick;
    int                         item_count;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_range_base = '0;
    in_range_top = '0;
    in_revoke = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    model_at_base = '0;
    model_map_words = '0;
    foreach (bitmap_model[i]) bitmap_model[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_AT_BASE: begin
          drain_block();
          write_reg(bmp_pkg::REG_AT_BASE, directed_rows[i].range_base);
        end
        ROW_MAP_WORDS: begin
          drain_block();
          write_reg(bmp_pkg::REG_MAP_WORDS, directed_rows[i].range_base);
        end
        default: begin
          send_paint(directed_rows[i].range_base, directed_rows[i].range_top,
                     directed_rows[i].revoke);
          if (directed_rows[i].typed) begin
            pending_reports.push_back(directed_rows[i].report);
            if (directed_rows[i].report.status) rejects_expected++;
          end else begin
            queue_reports();
          end
        end
      endcase
    end

    // Per-phase settings: full map, oversized, single word, empty, two random
    // sizes, then full map again; bases include wrapping and unaligned values.
    phase_at_base = '{32'h0000_0000, 32'hFFFF_FF00, $urandom & ~32'h7, 32'h0001_0000,
                      $urandom, 32'hFFFF_FFFF, $urandom & ~32'h7};
    phase_map_words = '{7'd64, 7'd127, 7'd1, 7'd0,
                        bmp_pkg::MAPW_W'($urandom_range(2, 63)),
                        bmp_pkg::MAPW_W'($urandom_range(65, 126)), 7'd64};

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_block();
      write_reg(bmp_pkg::REG_AT_BASE, phase_at_base[phase]);
      write_reg(bmp_pkg::REG_MAP_WORDS, 32'(phase_map_words[phase]));
      // One phase runs with no idling on either side.
      idle_pct = (phase == 2) ? 0 : IDLE_PCT;
      item_count = (phase_map_words[phase] == 0) ? 15 : PHASE_ITEMS;
      words = (model_map_words > bmp_pkg::MAP_WORDS) ? bmp_pkg::MAP_WORDS
                                                     : model_map_words;
      limit = words * bmp_pkg::WORD_BITS;
      for (int n = 0; n < item_count; n++) begin
        // Stall the result side long enough for the request queue to back up.
        if (phase == 1 && n == 10) sink_hold_len = SINK_HOLD;
        pick = $urandom_range(0, 99);
        revoke = $urandom_range(0, 1);
        if (limit >= 2 && pick < 78) begin
          start_bit = $urandom_range(0, limit - 2);
          if ($urandom_range(0, 99) < 85) span = $urandom_range(1, 100);
          else span = $urandom_range(1, limit - 1);
          end_bit = start_bit + span;
          if (end_bit > limit - 1) end_bit = limit - 1;
          range_base = model_at_base + 32'(start_bit * 8 + $urandom_range(0, 7));
          range_top = model_at_base + 32'(end_bit * 8 - 6 + $urandom_range(0, 7));
        end else if (pick < 86) begin
          // Top at or below the start bit: empty or reversed range.
          start_bit = $urandom_range(1, 4095);
          range_base = model_at_base + 32'(start_bit * 8 + $urandom_range(0, 7));
          range_top = model_at_base + 32'($urandom_range(0, start_bit * 8 - 6));
        end else if (pick < 93) begin
          start_bit = (limit != 0) ? $urandom_range(0, limit - 1) : 0;
          end_bit = limit + $urandom_range(0, 200);
          range_base = model_at_base + 32'(start_bit * 8);
          range_top = model_at_base + 32'(end_bit * 8 - 6 + $urandom_range(0, 7));
        end else begin
          range_base = $urandom;
          range_top = $urandom;
        end
        send_paint(range_base, range_top, revoke);
        queue_reports();
      end
    end

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d paint requests (%0d expected rejects) across %0d register writes.",
             requests_sent, rejects_expected, settings_written);
    $display("Checked %0d word reports, %0d field mismatches.", reports_checked,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
